@@ hw/rtl/qie_pkg.sv @@
// shared types, constants and codes of the quad instruction executor
`timescale 1ns / 1ps

package qie_pkg;

    localparam int VAR_SLOTS_DEF = 256;
    localparam int SLOT_W        = 8;
    localparam int SLOT_RANGE    = 1 << SLOT_W;
    localparam int DATA_W        = 64;
    localparam int CMD_W         = 5;
    localparam int QDEPTH        = 2;

    localparam logic [CMD_W-1:0] CMD_NOP    = 5'd0;
    localparam logic [CMD_W-1:0] CMD_GOTO   = 5'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_PRINT  = 5'd3;
    localparam logic [CMD_W-1:0] CMD_ASSIGN = 5'd4;
    localparam logic [CMD_W-1:0] CMD_ADD    = 5'd5;
    localparam logic [CMD_W-1:0] CMD_SUB    = 5'd6;
    localparam logic [CMD_W-1:0] CMD_MUL    = 5'd7;
    localparam logic [CMD_W-1:0] CMD_DIV    = 5'd8;
    localparam logic [CMD_W-1:0] CMD_LT     = 5'd9;
    localparam logic [CMD_W-1:0] CMD_GT     = 5'd10;
    localparam logic [CMD_W-1:0] CMD_EQ     = 5'd11;
    localparam logic [CMD_W-1:0] CMD_NE     = 5'd12;
    localparam logic [CMD_W-1:0] CMD_LE     = 5'd13;
    localparam logic [CMD_W-1:0] CMD_GE     = 5'd14;
    localparam logic [CMD_W-1:0] CMD_AND    = 5'd15;
    localparam logic [CMD_W-1:0] CMD_OR     = 5'd16;
    localparam logic [CMD_W-1:0] CMD_BREAK  = 5'd17;

    localparam logic [1:0] KIND_ABSENT = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_CHAR   = 2'd2;
    localparam logic [1:0] KIND_VAR    = 2'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_BRK  = 2'd2;
    localparam logic [1:0] ERR_HALT = 2'd3;

    typedef enum logic [3:0] {
        CLS_NOP, CLS_GOTO, CLS_READ, CLS_PRINT, CLS_ASSIGN,
        CLS_ALU, CLS_MUL, CLS_DIV, CLS_BREAK
    } op_class_t;

    typedef enum logic [2:0] {
        B_IDLE, B_EXEC, B_MUL, B_DIV, B_FIN
    } back_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [1:0]               first_kind;
        logic signed [DATA_W-1:0] first_literal;
        logic [SLOT_W-1:0]        first_slot;
        logic [1:0]               second_kind;
        logic signed [DATA_W-1:0] second_literal;
        logic [SLOT_W-1:0]        second_slot;
        logic                     dest_present;
        logic [SLOT_W-1:0]        dest_slot;
        logic signed [DATA_W-1:0] read_value;
        logic                     read_is_char;
    } in_word_t;

    typedef struct packed {
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
        logic                     print_as_char;
        logic                     branch_taken;
        logic [1:0]               error_code;
    } out_word_t;

    // classified quad as it waits between front and back
    typedef struct packed {
        op_class_t                cls;
        logic [CMD_W-1:0]         cmd;
        logic [1:0]               k1;
        logic [1:0]               k2;
        logic [DATA_W-1:0]        lit1;
        logic [DATA_W-1:0]        lit2;
        logic [SLOT_W-1:0]        idx_a;
        logic [SLOT_W-1:0]        idx_b;
        logic                     dest;
        logic [SLOT_W-1:0]        dest_idx;
        logic [DATA_W-1:0]        read_value;
        logic                     read_is_char;
    } quad_t;

    typedef struct packed {
        logic halted;
        logic clr_done;
    } back_status_t;

endpackage

@@ hw/rtl/quad_instruction_executor_unit.sv @@
// top level of the quad instruction executor
// a popped quad passes B_EXEC, then B_MUL for mul or B_DIV for div (nonzero divisor, not halted), then B_FIN
// the back end takes one quad at a time; mul sums three 32x32 partial products, div is radix-2
// a word waits in the two-entry queue until the back end takes it
// reset clears the variable store one row a cycle, all min(VAR_SLOTS, 256) rows;
// s_ready stays low until that pass is done, then the halted flag is clear
`timescale 1ns / 1ps

module quad_instruction_executor_unit #(
    parameter int VAR_SLOTS = qie_pkg::VAR_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qie_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output qie_pkg::out_word_t m_word
);

    qie_pkg::quad_t        entry;
    qie_pkg::quad_t        head;
    qie_pkg::back_status_t status;
    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_empty;

    qie_front #(.VAR_SLOTS(VAR_SLOTS)) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .q_full   (q_full),
        .clr_done (status.clr_done),
        .push     (push),
        .entry    (entry)
    );

    qie_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (entry),
        .pop     (pop),
        .dout    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    qie_back #(.VAR_SLOTS(VAR_SLOTS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .status  (status)
    );

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.clr_done |-> !s_ready)
        else $error("word accepted during store clear");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        status.halted |=> status.halted)
        else $error("halted flag dropped without reset");

    a_queue_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_full && q_empty) && !(pop && q_empty))
        else $error("queue pointer state broken");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while waiting");

endmodule

@@ hw/rtl/qie_front.sv @@
// front end: accepts quads, maps slots to store rows and classifies the command
`timescale 1ns / 1ps

module qie_front #(
    parameter int VAR_SLOTS = qie_pkg::VAR_SLOTS_DEF
) (
    input  logic             s_valid,
    output logic             s_ready,
    input  qie_pkg::in_word_t s_word,
    input  logic             q_full,
    input  logic             clr_done,
    output logic             push,
    output qie_pkg::quad_t   entry
);

    localparam int MEM_DEPTH = (VAR_SLOTS < qie_pkg::SLOT_RANGE) ? VAR_SLOTS
                                                                 : qie_pkg::SLOT_RANGE;

    logic [qie_pkg::SLOT_W-1:0] slot_map [qie_pkg::SLOT_RANGE];

    for (genvar i = 0; i < qie_pkg::SLOT_RANGE; i++) begin : g_map
        assign slot_map[i] = qie_pkg::SLOT_W'(i % MEM_DEPTH);
    end

    qie_pkg::op_class_t cls;

    always_comb begin
        case (s_word.cmd)
            qie_pkg::CMD_GOTO:   cls = qie_pkg::CLS_GOTO;
            qie_pkg::CMD_READ:   cls = qie_pkg::CLS_READ;
            qie_pkg::CMD_PRINT:  cls = qie_pkg::CLS_PRINT;
            qie_pkg::CMD_ASSIGN: cls = qie_pkg::CLS_ASSIGN;
            qie_pkg::CMD_MUL:    cls = qie_pkg::CLS_MUL;
            qie_pkg::CMD_DIV:    cls = qie_pkg::CLS_DIV;
            qie_pkg::CMD_BREAK:  cls = qie_pkg::CLS_BREAK;
            qie_pkg::CMD_ADD, qie_pkg::CMD_SUB, qie_pkg::CMD_LT, qie_pkg::CMD_GT,
            qie_pkg::CMD_EQ, qie_pkg::CMD_NE, qie_pkg::CMD_LE, qie_pkg::CMD_GE,
            qie_pkg::CMD_AND, qie_pkg::CMD_OR: cls = qie_pkg::CLS_ALU;
            default:             cls = qie_pkg::CLS_NOP;
        endcase
    end

    assign s_ready = !q_full && clr_done;
    assign push    = s_valid && s_ready;

    always_comb begin
        entry.cls          = cls;
        entry.cmd          = s_word.cmd;
        entry.k1           = s_word.first_kind;
        entry.k2           = s_word.second_kind;
        entry.lit1         = s_word.first_literal;
        entry.lit2         = s_word.second_literal;
        entry.idx_a        = slot_map[s_word.first_slot];
        // a read needs the destination type bit, not the second operand
        entry.idx_b        = (cls == qie_pkg::CLS_READ) ? slot_map[s_word.dest_slot]
                                                        : slot_map[s_word.second_slot];
        entry.dest         = s_word.dest_present;
        entry.dest_idx     = slot_map[s_word.dest_slot];
        entry.read_value   = s_word.read_value;
        entry.read_is_char = s_word.read_is_char;
    end

endmodule

@@ hw/rtl/qie_queue.sv @@
// short queue of classified quads between front and back
`timescale 1ns / 1ps

module qie_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  qie_pkg::quad_t din,
    input  logic           pop,
    output qie_pkg::quad_t dout,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = (qie_pkg::QDEPTH > 1) ? $clog2(qie_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(qie_pkg::QDEPTH + 1);

    qie_pkg::quad_t   mem_reg [qie_pkg::QDEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(qie_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(qie_pkg::QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(qie_pkg::QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

@@ hw/rtl/qie_div.sv @@
// unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module qie_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [qie_pkg::DATA_W-1:0] dividend,
    input  logic [qie_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [qie_pkg::DATA_W-1:0] quotient
);

    localparam int W     = qie_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
            quo_next = {quo_reg[W-2:0], !diff[W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

@@ hw/rtl/qie_back.sv @@
// back end: variable store, quad execution, multiply and divide sequencing and result register
`timescale 1ns / 1ps

module qie_back #(
    parameter int VAR_SLOTS = qie_pkg::VAR_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qie_pkg::quad_t        head,
    input  logic                  q_empty,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output qie_pkg::out_word_t    m_word,
    output qie_pkg::back_status_t status
);

    localparam int W         = qie_pkg::DATA_W;
    localparam int MEM_DEPTH = (VAR_SLOTS < qie_pkg::SLOT_RANGE) ? VAR_SLOTS
                                                                 : qie_pkg::SLOT_RANGE;
    localparam int IDX_W     = $clog2(MEM_DEPTH);

    // store word: type bit on top of the value
    logic [W:0] mem [MEM_DEPTH];
    logic [W:0] rd_a_reg;
    logic [W:0] rd_b_reg;

    qie_pkg::back_state_t state_reg, state_next;
    qie_pkg::quad_t       q_reg, q_next;
    qie_pkg::out_word_t   res_reg, res_next;
    qie_pkg::out_word_t   m_word_reg, m_word_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 halted_reg, halted_next;
    logic                 clr_done_reg, clr_done_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [W:0]           wr_data_reg, wr_data_next;
    logic [W-1:0]         opa_reg, opa_next;
    logic [W-1:0]         opb_reg, opb_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [1:0]           mcnt_reg, mcnt_next;
    logic                 neg_reg, neg_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [W:0]       wr_data;
    logic [W-1:0]     a, b;
    logic [W-1:0]     alu_r;
    logic [31:0]      mul_x, mul_y;
    logic [W-1:0]     prod;
    logic             div_start, div_done;
    logic [W-1:0]     div_q;
    logic             out_free;

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
    assign status  = '{halted: halted_reg, clr_done: clr_done_reg};
    assign pop     = (state_reg == qie_pkg::B_IDLE) && !q_empty && clr_done_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign wr_en   = !clr_done_reg || ((state_reg == qie_pkg::B_FIN) && out_free
                                        && wr_pend_reg);
    assign wr_addr = clr_done_reg ? q_reg.dest_idx[IDX_W-1:0] : clr_cnt_reg;
    assign wr_data = clr_done_reg ? wr_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[head.idx_a[IDX_W-1:0]];
        rd_b_reg <= mem[head.idx_b[IDX_W-1:0]];
    end

    // operand selection on the quad just popped
    always_comb begin
        case (q_reg.k1)
            qie_pkg::KIND_NUMBER, qie_pkg::KIND_CHAR: a = q_reg.lit1;
            qie_pkg::KIND_VAR:                        a = rd_a_reg[W-1:0];
            default:                                  a = '0;
        endcase
        case (q_reg.k2)
            qie_pkg::KIND_NUMBER, qie_pkg::KIND_CHAR: b = q_reg.lit2;
            qie_pkg::KIND_VAR:                        b = rd_b_reg[W-1:0];
            default:                                  b = '0;
        endcase
    end

    always_comb begin
        case (q_reg.cmd)
            qie_pkg::CMD_ADD: alu_r = a + b;
            qie_pkg::CMD_SUB: alu_r = a - b;
            qie_pkg::CMD_LT:  alu_r = W'($signed(a) < $signed(b));
            qie_pkg::CMD_GT:  alu_r = W'($signed(a) > $signed(b));
            qie_pkg::CMD_EQ:  alu_r = W'(a == b);
            qie_pkg::CMD_NE:  alu_r = W'(a != b);
            qie_pkg::CMD_LE:  alu_r = W'($signed(a) <= $signed(b));
            qie_pkg::CMD_GE:  alu_r = W'($signed(a) >= $signed(b));
            qie_pkg::CMD_AND: alu_r = W'((a != '0) && (b != '0));
            qie_pkg::CMD_OR:  alu_r = W'((a != '0) || (b != '0));
            default:          alu_r = '0;
        endcase
    end

    // low 64 bits of the product from three 32x32 partial products
    assign mul_x = (mcnt_reg == 2'd2) ? opa_reg[W-1:32] : opa_reg[31:0];
    assign mul_y = (mcnt_reg == 2'd1) ? opb_reg[W-1:32] : opb_reg[31:0];
    assign prod  = mul_x * mul_y;

    assign div_start = (state_reg == qie_pkg::B_EXEC) && !halted_reg
                       && (q_reg.cls == qie_pkg::CLS_DIV) && (b != '0);

    qie_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (a[W-1] ? (~a + 1'b1) : a),
        .divisor  (b[W-1] ? (~b + 1'b1) : b),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next    = state_reg;
        q_next        = q_reg;
        res_next      = res_reg;
        m_word_next   = m_word_reg;
        m_valid_next  = m_valid_reg;
        halted_next   = halted_reg;
        clr_done_next = clr_done_reg;
        clr_cnt_next  = clr_cnt_reg;
        wr_pend_next  = wr_pend_reg;
        wr_data_next  = wr_data_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        acc_next      = acc_reg;
        mcnt_next     = mcnt_reg;
        neg_next      = neg_reg;

        if (!clr_done_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(MEM_DEPTH - 1)) begin
                clr_done_next = 1'b1;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            qie_pkg::B_IDLE: begin
                if (pop) begin
                    q_next     = head;
                    state_next = qie_pkg::B_EXEC;
                end
            end
            qie_pkg::B_EXEC: begin
                res_next     = '0;
                wr_pend_next = 1'b0;
                wr_data_next = {1'b0, alu_r};
                opa_next     = a;
                opb_next     = b;
                mcnt_next    = 2'd0;
                neg_next     = a[W-1] ^ b[W-1];
                state_next   = qie_pkg::B_FIN;
                if (halted_reg) begin
                    res_next.error_code = qie_pkg::ERR_HALT;
                end else begin
                    case (q_reg.cls)
                        qie_pkg::CLS_GOTO: begin
                            res_next.branch_taken = (q_reg.k1 == qie_pkg::KIND_ABSENT)
                                                    || (a != '0);
                        end
                        qie_pkg::CLS_READ: begin
                            // a char destination keeps its type
                            wr_pend_next = q_reg.dest;
                            wr_data_next = {rd_b_reg[W] | q_reg.read_is_char,
                                            q_reg.read_value};
                        end
                        qie_pkg::CLS_PRINT: begin
                            if (q_reg.k1 != qie_pkg::KIND_ABSENT) begin
                                res_next.print_valid   = 1'b1;
                                res_next.print_value   = a;
                                res_next.print_as_char = (q_reg.k1 == qie_pkg::KIND_CHAR)
                                    || ((q_reg.k1 == qie_pkg::KIND_VAR) && rd_a_reg[W]);
                            end
                        end
                        qie_pkg::CLS_ASSIGN: begin
                            wr_pend_next = q_reg.dest && (q_reg.k1 != qie_pkg::KIND_ABSENT);
                            wr_data_next = {(q_reg.k1 == qie_pkg::KIND_CHAR)
                                || ((q_reg.k1 == qie_pkg::KIND_VAR) && rd_a_reg[W]), a};
                        end
                        qie_pkg::CLS_ALU: begin
                            wr_pend_next = q_reg.dest;
                        end
                        qie_pkg::CLS_MUL: begin
                            state_next = qie_pkg::B_MUL;
                        end
                        qie_pkg::CLS_DIV: begin
                            if (b == '0) begin
                                res_next.error_code = qie_pkg::ERR_DIV0;
                                halted_next         = 1'b1;
                            end else begin
                                state_next = qie_pkg::B_DIV;
                            end
                        end
                        qie_pkg::CLS_BREAK: begin
                            res_next.error_code = qie_pkg::ERR_BRK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            qie_pkg::B_MUL: begin
                if (mcnt_reg == 2'd0) begin
                    acc_next = prod;
                end else begin
                    acc_next = acc_reg + {prod[31:0], 32'b0};
                end
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd2) begin
                    wr_pend_next = q_reg.dest;
                    wr_data_next = {1'b0, acc_next};
                    state_next   = qie_pkg::B_FIN;
                end
            end
            qie_pkg::B_DIV: begin
                if (div_done) begin
                    wr_pend_next = q_reg.dest;
                    wr_data_next = {1'b0, neg_reg ? (~div_q + 1'b1) : div_q};
                    state_next   = qie_pkg::B_FIN;
                end
            end
            qie_pkg::B_FIN: begin
                if (out_free) begin
                    m_word_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = qie_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = qie_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= qie_pkg::B_IDLE;
            m_valid_reg  <= 1'b0;
            halted_reg   <= 1'b0;
            clr_done_reg <= 1'b0;
            clr_cnt_reg  <= '0;
            wr_pend_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            halted_reg   <= halted_next;
            clr_done_reg <= clr_done_next;
            clr_cnt_reg  <= clr_cnt_next;
            wr_pend_reg  <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg       <= q_next;
        res_reg     <= res_next;
        m_word_reg  <= m_word_next;
        wr_data_reg <= wr_data_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        acc_reg     <= acc_next;
        mcnt_reg    <= mcnt_next;
        neg_reg     <= neg_next;
    end

endmodule
